[design/x86_opcode_sweep_classifier_assert.svh]
// assertion macros, clocked on clk, off while rst_n is low
`ifndef X86_OPCODE_SWEEP_CLASSIFIER_ASSERT_SVH
`define X86_OPCODE_SWEEP_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define X86OS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x86os assertion failed");

// next-cycle implication
`define X86OS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x86os assertion failed");

`endif

[design/x86os_pkg.sv]
package x86os_pkg;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_REX,
        MODE_FF,
        MODE_OPSZ
    } mode_t;

    typedef enum logic [4:0] {
        MN_ADD_AND,
        MN_TEST,
        MN_MOV,
        MN_LEA,
        MN_RETQ,
        MN_JE,
        MN_PUSHQ,
        MN_JMPQ,
        MN_CALLQ,
        MN_NOPL,
        MN_NOPW,
        MN_XCHG,
        MN_PUSH,
        MN_POP,
        MN_XOR,
        MN_HLT,
        MN_JNE
    } mnemonic_t;

    localparam logic [7:0] OP_REX_W    = 8'h48;
    localparam logic [7:0] OP_GRP5     = 8'hff;
    localparam logic [7:0] OP_OPSZ     = 8'h66;
    localparam logic [7:0] OP_RET      = 8'hc3;
    localparam logic [7:0] OP_JE       = 8'h74;
    localparam logic [7:0] OP_JNE      = 8'h75;
    localparam logic [7:0] OP_ESC      = 8'h0f;
    localparam logic [7:0] OP_PUSH_IMM = 8'h68;
    localparam logic [7:0] OP_JMP_REL  = 8'he9;
    localparam logic [7:0] OP_PUSH_RBP = 8'h55;
    localparam logic [7:0] OP_POP_RSI  = 8'h5e;
    localparam logic [7:0] OP_POP_RBX  = 8'h5b;
    localparam logic [7:0] OP_POP_RBP  = 8'h5d;
    localparam logic [7:0] OP_POP_ALT  = 8'h4e;
    localparam logic [7:0] OP_XOR      = 8'h31;
    localparam logic [7:0] OP_HLT      = 8'hf4;
    localparam logic [7:0] OP_ALU_IMM8 = 8'h83;
    localparam logic [7:0] OP_TEST     = 8'h85;
    localparam logic [7:0] OP_MOV      = 8'h89;
    localparam logic [7:0] OP_LEA      = 8'h8d;
    localparam logic [7:0] OP_MODRM_35 = 8'h35;
    localparam logic [7:0] OP_MODRM_25 = 8'h25;
    localparam logic [7:0] OP_CS       = 8'h2e;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned SKIP_W = 3;

    typedef struct packed {
        logic [ADDR_W-1:0] instr_address;
        mnemonic_t         mnemonic;
    } result_t;

    typedef struct packed {
        logic              hit;
        logic              prefixed;
        mnemonic_t         code;
        logic [SKIP_W-1:0] skip;
        mode_t             mode;
    } decode_t;

    function automatic decode_t decode_byte(mode_t mode, logic [7:0] b);
        decode_t d;
        d.hit      = 1'b1;
        d.prefixed = (mode != MODE_NONE);
        d.code     = MN_ADD_AND;
        d.skip     = '0;
        d.mode     = MODE_NONE;
        case (mode)
            MODE_REX:
            begin
                case (b)
                    OP_ALU_IMM8: begin d.code = MN_ADD_AND; d.skip = 3'd2; end
                    OP_TEST:     begin d.code = MN_TEST;    d.skip = 3'd1; end
                    OP_MOV:      begin d.code = MN_MOV;     d.skip = 3'd1; end
                    OP_LEA:      begin d.code = MN_LEA;     d.skip = 3'd5; end
                    default:     d.hit = 1'b0;
                endcase
            end
            MODE_FF:
            begin
                case (b)
                    OP_MODRM_35: begin d.code = MN_PUSHQ; d.skip = 3'd4; end
                    OP_MODRM_25: begin d.code = MN_JMPQ;  d.skip = 3'd4; end
                    default:     begin d.code = MN_CALLQ; d.skip = 3'd1; end
                endcase
            end
            MODE_OPSZ:
            begin
                case (b)
                    OP_CS:   begin d.code = MN_NOPW; d.skip = 3'd5; end
                    default: begin d.code = MN_XCHG; d.skip = 3'd0; end
                endcase
            end
            default:
            begin
                case (b)
                    OP_REX_W:    begin d.hit = 1'b0; d.mode = MODE_REX;  end
                    OP_GRP5:     begin d.hit = 1'b0; d.mode = MODE_FF;   end
                    OP_OPSZ:     begin d.hit = 1'b0; d.mode = MODE_OPSZ; end
                    OP_RET:      d.code = MN_RETQ;
                    OP_JE:       begin d.code = MN_JE;    d.skip = 3'd1; end
                    OP_ESC:      begin d.code = MN_NOPL;  d.skip = 3'd3; end
                    OP_PUSH_IMM: begin d.code = MN_PUSHQ; d.skip = 3'd4; end
                    OP_JMP_REL:  begin d.code = MN_JMPQ;  d.skip = 3'd4; end
                    OP_PUSH_RBP: d.code = MN_PUSH;
                    OP_POP_RSI,
                    OP_POP_RBX,
                    OP_POP_RBP,
                    OP_POP_ALT:  d.code = MN_POP;
                    OP_XOR:      begin d.code = MN_XOR;   d.skip = 3'd1; end
                    OP_HLT:      d.code = MN_HLT;
                    OP_JNE:      begin d.code = MN_JNE;   d.skip = 3'd1; end
                    default:     d.hit = 1'b0;
                endcase
            end
        endcase
        return d;
    endfunction

endpackage

[design/x86os_scan.sv]
`include "x86_opcode_sweep_classifier_assert.svh"

module x86os_scan
    import x86os_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] base_offset,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        code_byte,
    input  logic              last_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    logic              stg_valid_reg, stg_valid_next;
    logic [7:0]        stg_byte_reg;
    logic              stg_last_reg;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] pfx_pos_reg, pfx_pos_next;
    mode_t             mode_reg, mode_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    decode_t           dec;
    logic              skipping;
    logic              hit;
    logic              advance;

    assign dec      = decode_byte(mode_reg, stg_byte_reg);
    assign skipping = (skip_reg != '0);
    assign hit      = !skipping && dec.hit;
    assign advance  = stg_valid_reg && (!hit || res_ready);
    assign in_ready = !stg_valid_reg || advance;

    assign res_valid         = stg_valid_reg && hit;
    assign res.instr_address = base_offset + (dec.prefixed ? pfx_pos_reg : cur_reg);
    assign res.mnemonic      = dec.code;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        cur_next       = cur_reg;
        pfx_pos_next   = pfx_pos_reg;
        mode_next      = mode_reg;
        skip_next      = skip_reg;
        if (advance)
        begin
            stg_valid_next = 1'b0;
            if (skipping)
            begin
                skip_next = skip_reg - 3'd1;
            end
            else
            begin
                mode_next = dec.mode;
                if (dec.hit)
                begin
                    skip_next = dec.skip;
                end
                if (dec.mode != MODE_NONE)
                begin
                    pfx_pos_next = cur_reg;
                end
            end
            if (stg_last_reg)
            begin
                cur_next  = '0;
                mode_next = MODE_NONE;
                skip_next = '0;
            end
            else
            begin
                cur_next = cur_reg + 64'd1;
            end
        end
        if (in_valid && in_ready)
        begin
            stg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            cur_reg       <= '0;
            mode_reg      <= MODE_NONE;
            skip_reg      <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            cur_reg       <= cur_next;
            mode_reg      <= mode_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfx_pos_reg <= pfx_pos_next;
        if (in_valid && in_ready)
        begin
            stg_byte_reg <= code_byte;
            stg_last_reg <= last_byte;
        end
    end

    `X86OS_ASSERT_NOW(a_skip_no_prefix, skip_reg != '0, mode_reg == MODE_NONE)
    `X86OS_ASSERT_NOW(a_res_needs_item, res_valid, stg_valid_reg && skip_reg == '0)
    `X86OS_ASSERT_NEXT(a_last_clears, advance && stg_last_reg,
        cur_reg == '0 && mode_reg == MODE_NONE && skip_reg == '0)
    `X86OS_ASSERT_NOW(a_skip_range, 1'b1, skip_reg <= 3'd5)

endmodule

[design/x86os_out_stage.sv]
module x86os_out_stage
    import x86os_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

[design/x86_opcode_sweep_classifier.sv]
// channel   dir  signals                         word
// s_axis    in   s_tvalid s_tready s_tdata s_tlast  one code byte, tlast = last of buffer
// m_axis    out  m_tvalid m_tready m_tdata          instruction start address and mnemonic
// cfg       in   cfg_valid cfg_ready cfg_data       base offset of each buffer
//
// one byte per cycle sustained while no result is stalled, via the input byte register and the result register
// the byte decode, position step and address add sit between input and result register
// cfg_ready is always high, a new offset applies from the next byte decoded
// rst_n clears the scan state, base offset and both valid flags at once
// a stalled result holds the result register and the byte behind it, nothing is lost

module x86_opcode_sweep_classifier
    import x86os_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] instr_address, [68:64] mnemonic, [71:69] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    logic [ADDR_W-1:0] base_offset_reg, base_offset_next;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    result_t           out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_offset_next = base_offset_reg;
        if (cfg_valid && cfg_ready)
        begin
            base_offset_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
        end
        else
        begin
            base_offset_reg <= base_offset_next;
        end
    end

    x86os_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_offset (base_offset_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .code_byte   (s_tdata),
        .last_byte   (s_tlast),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    x86os_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, 5'(out_res.mnemonic), out_res.instr_address};

endmodule

[sim/x86_opcode_sweep_classifier_test.sv]
`timescale 1ns / 100ps

module x86_opcode_sweep_classifier_test;
    import x86os_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] code_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [63:0] instr_address, [68:64] mnemonic, [71:69] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    // scan state mirrored by the predictor
    logic [63:0] cur_base_offset;
    logic [63:0] scan_pos;
    mode_t       scan_mode;
    logic [2:0]  skip_left;

    result_t     expected_instrs[$];
    logic [7:0]  buf_bytes[$];

    int          failures;
    int          sent_count;
    int          burst_left;
    bit          no_gaps;

    // receiver stall pattern
    int          stall_hold;
    int          stall_style;
    int          style_left;
    int          phase_cnt;

    x86_opcode_sweep_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            m_tready   <= 1'b0;
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style <= $urandom_range(0, 3);
                style_left  <= $urandom_range(16, 200);
            end
            else
            begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 2) == 0);
                default: m_tready <= ((phase_cnt % 7) < 4);
            endcase
            phase_cnt <= phase_cnt + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_instrs.size() == 0)
            begin
                failures++;
                if (failures < 50)
                    $display("%0t unexpected word: expected none actual %h", $realtime, m_tdata);
            end
            else
            begin
                if (m_tdata[63:0] !== expected_instrs[0].instr_address)
                begin
                    failures++;
                    if (failures < 50)
                        $display("%0t instr_address: expected %h actual %h", $realtime,
                                 expected_instrs[0].instr_address, m_tdata[63:0]);
                end
                if (m_tdata[68:64] !== expected_instrs[0].mnemonic)
                begin
                    failures++;
                    if (failures < 50)
                        $display("%0t mnemonic: expected %0d actual %0d", $realtime,
                                 expected_instrs[0].mnemonic, m_tdata[68:64]);
                end
                expected_instrs.pop_front();
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic classify_byte(input logic [7:0] b, input logic is_last);
        logic [63:0] here;
        logic        found;
        logic        prefixed;
        mnemonic_t   code;
        logic [2:0]  operands;
        result_t     r;
        here     = cur_base_offset + scan_pos;
        found    = 1'b0;
        prefixed = 1'b0;
        code     = MN_ADD_AND;
        operands = 3'd0;
        if (skip_left != 3'd0)
        begin
            skip_left = skip_left - 3'd1;
        end
        else if (scan_mode == MODE_REX)
        begin
            prefixed = 1'b1;
            found    = 1'b1;
            case (b)
                OP_ALU_IMM8: begin code = MN_ADD_AND; operands = 3'd2; end
                OP_TEST:     begin code = MN_TEST;    operands = 3'd1; end
                OP_MOV:      begin code = MN_MOV;     operands = 3'd1; end
                OP_LEA:      begin code = MN_LEA;     operands = 3'd5; end
                default:     found = 1'b0;
            endcase
            scan_mode = MODE_NONE;
        end
        else if (scan_mode == MODE_FF)
        begin
            prefixed = 1'b1;
            found    = 1'b1;
            if (b == OP_MODRM_35)
            begin
                code = MN_PUSHQ; operands = 3'd4;
            end
            else if (b == OP_MODRM_25)
            begin
                code = MN_JMPQ; operands = 3'd4;
            end
            else
            begin
                code = MN_CALLQ; operands = 3'd1;
            end
            scan_mode = MODE_NONE;
        end
        else if (scan_mode == MODE_OPSZ)
        begin
            prefixed = 1'b1;
            found    = 1'b1;
            if (b == OP_CS)
            begin
                code = MN_NOPW; operands = 3'd5;
            end
            else
            begin
                code = MN_XCHG; operands = 3'd0;
            end
            scan_mode = MODE_NONE;
        end
        else
        begin
            found = 1'b1;
            case (b)
                OP_REX_W:    begin found = 1'b0; scan_mode = MODE_REX;  end
                OP_GRP5:     begin found = 1'b0; scan_mode = MODE_FF;   end
                OP_OPSZ:     begin found = 1'b0; scan_mode = MODE_OPSZ; end
                OP_RET:      code = MN_RETQ;
                OP_JE:       begin code = MN_JE;    operands = 3'd1; end
                OP_ESC:      begin code = MN_NOPL;  operands = 3'd3; end
                OP_PUSH_IMM: begin code = MN_PUSHQ; operands = 3'd4; end
                OP_JMP_REL:  begin code = MN_JMPQ;  operands = 3'd4; end
                OP_PUSH_RBP: code = MN_PUSH;
                OP_POP_RSI,
                OP_POP_RBX,
                OP_POP_RBP,
                OP_POP_ALT:  code = MN_POP;
                OP_XOR:      begin code = MN_XOR;   operands = 3'd1; end
                OP_HLT:      code = MN_HLT;
                OP_JNE:      begin code = MN_JNE;   operands = 3'd1; end
                default:     found = 1'b0;
            endcase
        end
        if (found)
        begin
            skip_left       = operands;
            r.instr_address = prefixed ? here - 64'd1 : here;
            r.mnemonic      = code;
            expected_instrs.push_back(r);
        end
        if (is_last)
        begin
            scan_pos  = 64'd0;
            scan_mode = MODE_NONE;
            skip_left = 3'd0;
        end
        else
        begin
            scan_pos = scan_pos + 64'd1;
        end
    endtask

    task automatic send_code_byte(input logic [7:0] b, input logic is_last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        classify_byte(b, is_last);
        sent_count++;
        if (burst_left > 0 || no_gaps)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
    endtask

    task automatic send_buffer(input int n);
        for (int i = 0; i < n; i++)
            send_code_byte(buf_bytes[i], i == n - 1);
        buf_bytes.delete();
    endtask

    task automatic wait_scan_idle();
        s_tvalid <= 1'b0;
        while (expected_instrs.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_base_offset(input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid       <= 1'b0;
        cur_base_offset  = v;
    endtask

    task automatic push_operands(input int n);
        repeat (n) buf_bytes.push_back(rand_byte());
    endtask

    task automatic append_instr();
        case ($urandom_range(0, 24))
            0:  buf_bytes.push_back(OP_RET);
            1:  begin buf_bytes.push_back(OP_JE);       push_operands(1); end
            2:  begin buf_bytes.push_back(OP_ESC);      push_operands(3); end
            3:  begin buf_bytes.push_back(OP_PUSH_IMM); push_operands(4); end
            4:  begin buf_bytes.push_back(OP_JMP_REL);  push_operands(4); end
            5:  buf_bytes.push_back(OP_PUSH_RBP);
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       buf_bytes.push_back(OP_POP_RSI);
                    1:       buf_bytes.push_back(OP_POP_RBX);
                    2:       buf_bytes.push_back(OP_POP_RBP);
                    default: buf_bytes.push_back(OP_POP_ALT);
                endcase
            end
            7:  begin buf_bytes.push_back(OP_XOR);      push_operands(1); end
            8:  buf_bytes.push_back(OP_HLT);
            9:  begin buf_bytes.push_back(OP_JNE);      push_operands(1); end
            10: begin buf_bytes.push_back(OP_REX_W); buf_bytes.push_back(OP_ALU_IMM8);
                      push_operands(2); end
            11: begin buf_bytes.push_back(OP_REX_W); buf_bytes.push_back(OP_TEST);
                      push_operands(1); end
            12: begin buf_bytes.push_back(OP_REX_W); buf_bytes.push_back(OP_MOV);
                      push_operands(1); end
            13: begin buf_bytes.push_back(OP_REX_W); buf_bytes.push_back(OP_LEA);
                      push_operands(5); end
            14: begin buf_bytes.push_back(OP_GRP5); buf_bytes.push_back(OP_MODRM_35);
                      push_operands(4); end
            15: begin buf_bytes.push_back(OP_GRP5); buf_bytes.push_back(OP_MODRM_25);
                      push_operands(4); end
            16: begin buf_bytes.push_back(OP_GRP5); push_operands(2); end
            17: begin buf_bytes.push_back(OP_OPSZ); buf_bytes.push_back(OP_CS);
                      push_operands(5); end
            18: begin buf_bytes.push_back(OP_OPSZ); push_operands(1); end
            19: begin buf_bytes.push_back(OP_REX_W); push_operands(1); end
            default: push_operands(1);
        endcase
    endtask

    task automatic test_plain_opcodes();
        // one-byte forms, skipped operands, a skip dropped at end of buffer
        send_code_byte(OP_RET, 1'b0);
        send_code_byte(OP_JE, 1'b0);
        send_code_byte(OP_RET, 1'b0);
        send_code_byte(OP_PUSH_RBP, 1'b0);
        send_code_byte(OP_POP_RSI, 1'b0);
        send_code_byte(OP_POP_RBX, 1'b0);
        send_code_byte(OP_POP_RBP, 1'b0);
        send_code_byte(OP_POP_ALT, 1'b0);
        send_code_byte(OP_HLT, 1'b0);
        send_code_byte(8'h00, 1'b0);
        send_code_byte(OP_XOR, 1'b0);
        send_code_byte(8'h00, 1'b0);
        send_code_byte(OP_JNE, 1'b0);
        send_code_byte(OP_GRP5, 1'b0);
        send_code_byte(OP_ESC, 1'b1);
        send_code_byte(OP_PUSH_IMM, 1'b1);
        send_code_byte(OP_JMP_REL, 1'b1);
        wait_scan_idle();
    endtask

    task automatic test_prefixed_opcodes();
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_ALU_IMM8, 1'b0);
        send_code_byte(8'hff, 1'b0);
        send_code_byte(8'h00, 1'b0);
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_TEST, 1'b0);
        send_code_byte(8'h80, 1'b0);
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_MOV, 1'b0);
        send_code_byte(8'h7f, 1'b0);
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_LEA, 1'b1);
        send_code_byte(OP_GRP5, 1'b0);
        send_code_byte(OP_MODRM_35, 1'b1);
        send_code_byte(OP_GRP5, 1'b0);
        send_code_byte(OP_MODRM_25, 1'b1);
        send_code_byte(OP_GRP5, 1'b0);
        send_code_byte(OP_GRP5, 1'b0);
        send_code_byte(OP_RET, 1'b0);
        send_code_byte(OP_OPSZ, 1'b0);
        send_code_byte(OP_CS, 1'b1);
        send_code_byte(OP_OPSZ, 1'b0);
        send_code_byte(OP_OPSZ, 1'b0);
        // second rex byte is not an opcode, prefix just dropped
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_REX_W, 1'b0);
        send_code_byte(OP_RET, 1'b0);
        send_code_byte(OP_REX_W, 1'b1);
        send_code_byte(OP_TEST, 1'b1);
        wait_scan_idle();
    endtask

    task automatic test_base_offset();
        // address sum wraps past the top
        write_base_offset(64'hffff_ffff_ffff_ffff);
        send_code_byte(OP_RET, 1'b0);
        send_code_byte(OP_PUSH_RBP, 1'b0);
        send_code_byte(OP_REX_W, 1'b0);
        wait_scan_idle();
        // new offset in the middle of a buffer
        write_base_offset(64'h8000_0000_0000_0000);
        send_code_byte(OP_TEST, 1'b0);
        send_code_byte(8'h01, 1'b0);
        send_code_byte(OP_HLT, 1'b1);
        wait_scan_idle();
        write_base_offset(64'h0000_0000_0000_0000);
        send_code_byte(OP_OPSZ, 1'b0);
        send_code_byte(OP_RET, 1'b1);
        wait_scan_idle();
        write_base_offset(64'h1234_5678_9abc_def0);
    endtask

    task automatic test_backpressure();
        wait_scan_idle();
        no_gaps     = 1'b1;
        stall_hold <= 400;
        for (int i = 0; i < 80; i++)
        begin
            case (i % 4)
                0:       send_code_byte(OP_RET, 1'b0);
                1:       send_code_byte(OP_PUSH_RBP, 1'b0);
                2:       send_code_byte(OP_HLT, 1'b0);
                default: send_code_byte(OP_POP_RBX, i == 79);
            endcase
        end
        no_gaps = 1'b0;
        wait_scan_idle();
    endtask

    task automatic test_random_stream();
        int len;
        int n;
        logic [63:0] v;
        while (sent_count < 1950)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_scan_idle();
                v = {$urandom, $urandom};
                case ($urandom_range(0, 4))
                    0:       v = 64'd0;
                    1:       v = 64'hffff_ffff_ffff_ffff;
                    2:       v = 64'hffff_ffff_ffff_ffff - $urandom_range(0, 40);
                    default: ;
                endcase
                write_base_offset(v);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
            while (buf_bytes.size() < len)
                append_instr();
            // some buffers end in the middle of an instruction
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, buf_bytes.size())
                                            : buf_bytes.size();
            send_buffer(n);
        end
        wait_scan_idle();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = 64'd0;
        cur_base_offset = 64'd0;
        scan_pos        = 64'd0;
        scan_mode       = MODE_NONE;
        skip_left       = 3'd0;
        failures        = 0;
        sent_count      = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        stall_hold      = 0;
        stall_style     = 0;
        style_left      = 0;
        phase_cnt       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_opcodes();
        test_prefixed_opcodes();
        test_base_offset();
        test_backpressure();
        test_random_stream();

        wait_scan_idle();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
